### rtl/osm_pkg.sv
`timescale 1ns / 1ps

package osm_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 31;
  localparam int RANK_W   = 6;
  localparam int ECNT_W   = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [KEY_W-1:0]    key;
    logic [RANK_W-1:0]   rank;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]    rank_value;
    logic                rank_valid;
    logic                insert_dropped;
    logic [ECNT_W-1:0]   element_count;
  } out_t;

  typedef struct packed {
    logic en;
    in_t  item;
  } store_req_t;

endpackage

### rtl/osm_store.sv
`timescale 1ns / 1ps

module osm_store (
  input  logic              clk,
  input  logic              rst_n,
  input  osm_pkg::store_req_t req,
  output osm_pkg::out_t     rsp
);
  import osm_pkg::*;

  logic [KEY_W-1:0]    keys_r   [CAPACITY];
  logic [KEY_W-1:0]    keys_nxt [CAPACITY];
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CAPACITY-1:0] le_w;
  logic [CAPACITY-1:0] lt_w;
  logic                found_w;
  logic                full_w;
  logic                dropped_w;
  logic [KEY_W-1:0]    sel_w;

  assign full_w = (count_r == CNT_W'(CAPACITY));

  // per-cell compares against the incoming key, masked to occupied cells
  always_comb begin
    found_w = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      le_w[i] = (CNT_W'(i) < count_r) && (keys_r[i] <= req.item.key);
      lt_w[i] = (CNT_W'(i) < count_r) && (keys_r[i] <  req.item.key);
      if ((CNT_W'(i) < count_r) && (keys_r[i] == req.item.key)) found_w = 1'b1;
    end
  end

  always_comb begin
    keys_nxt  = keys_r;
    count_nxt = count_r;
    dropped_w = 1'b0;
    case (req.item.func)
      FUNC_INSERT: begin
        if (full_w) begin
          dropped_w = 1'b1;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          // new copy lands after all keys <= it, the tail moves up one cell
          if (!le_w[0]) keys_nxt[0] = req.item.key;
          for (int i = 1; i < CAPACITY; i++) begin
            if (!le_w[i]) keys_nxt[i] = le_w[i-1] ? req.item.key : keys_r[i-1];
          end
        end
      end
      FUNC_REMOVE: begin
        if (found_w) begin
          count_nxt = count_r - CNT_W'(1);
          // first equal copy sits right after the smaller keys
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (!lt_w[i]) keys_nxt[i] = keys_r[i+1];
          end
        end
      end
      default: begin
        keys_nxt = keys_r;
      end
    endcase
  end

  always_comb begin
    sel_w = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(req.item.rank) == i) sel_w = keys_nxt[i];
    end
  end

  always_comb begin
    rsp.rank_valid     = 32'(req.item.rank) < 32'(count_nxt);
    rsp.rank_value     = rsp.rank_valid ? sel_w : '0;
    rsp.insert_dropped = dropped_w;
    rsp.element_count  = ECNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (req.en) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      keys_r <= keys_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    req.en && req.item.func == FUNC_INSERT && full_w |=> count_r == $past(count_r))
    else $error("insert into full store changed the count");

  a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
    req.en && req.item.func == FUNC_REMOVE
    |=> (count_r == $past(count_r)) || (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove changed the count by more than one");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> keys_r[0] <= keys_r[1])
    else $error("store head out of order");
`endif

endmodule

### rtl/order_statistic_multiset_top.sv
`timescale 1ns / 1ps

// sorted multiset of 31-bit keys with a rank query per item
// in channel: in_valid/in_ready carry one beat {func, key, rank}; func selects
//   insert or remove of one copy of key, rank asks for the key at that position
//   in ascending order after the update
// out channel: out_valid/out_ready carry one beat per input beat
//   {rank_value, rank_valid, insert_dropped, element_count}, in input order
// pipeline: input beat to result beat through the input register, then the
//   store update and rank select into the result register
// throughput: one beat per cycle while out_ready holds; the key cells compare
//   and shift in parallel, so the store update is combinational between registers
// receiver stall: the result register holds; the input register still takes
//   one more beat if empty, after which in_ready drops until the result is taken
// reset: synchronous rst_n low empties the store (count zero) and clears both
//   valid flags; key cells hold stale data that is never read
module order_statistic_multiset_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  osm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output osm_pkg::out_t out_data
);
  import osm_pkg::*;

  logic       in_valid_r;
  in_t        in_r;
  logic       out_valid_r;
  out_t       out_r;
  logic       advance_w;
  store_req_t req_w;
  out_t       rsp_w;

  assign advance_w = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance_w;

  assign req_w.en   = advance_w;
  assign req_w.item = in_r;

  osm_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_w),
    .rsp   (rsp_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance_w) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_r <= in_data;
    if (advance_w) out_r <= rsp_w;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
